// File: src/block_transfer_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// Block transfer receiver: assertion macros
// Concurrent assertion wrappers used by the receiver top level. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSFER_RECEIVER_TOP_DEFINES_SVH
`define BLOCK_TRANSFER_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define BTR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define BTR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define BTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BTR_ASSERT(lbl, cond, msg)
`define BTR_ASSERT_IMPL(lbl, ante, cons, msg)
`define BTR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/btr_pkg.sv
// ----------------------------------------------------------------------------
// Block transfer receiver package
// Word types, message codes, phase and status encodings of the receiver.
// ----------------------------------------------------------------------------
package btr_pkg;

    // Largest block length that is accepted.
    localparam logic [7:0] MAX_BLOCK_LEN = 8'd128;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;
    localparam logic [7:0] SEQ_RESET = 8'd1;
    localparam logic [7:0] ERR_MAX = 8'hff;

    // Operations of an input word.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_MESSAGE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Control message codes.
    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_CAN = 8'h18;

    // Reply codes.
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_NAK = 2'd1;
    localparam logic [1:0] REPLY_ACK = 2'd2;
    localparam logic [1:0] REPLY_CAN = 2'd3;

    // Session status codes.
    localparam logic [2:0] STATUS_IDLE = 3'd0;
    localparam logic [2:0] STATUS_RUN = 3'd1;
    localparam logic [2:0] STATUS_DONE = 3'd2;
    localparam logic [2:0] STATUS_ABORT = 3'd3;
    localparam logic [2:0] STATUS_CANCEL = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HANDSHAKE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] command_code;
        logic [7:0] seq_first;
        logic [7:0] seq_second;
        logic [7:0] block_len;
        logic       data_ok;
        logic       sink_ok;
        logic       space_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]  reply_code;
        logic        deliver;
        logic [7:0]  delivered_len;
        logic [2:0]  session_status;
        logic [15:0] blocks_received;
    } result_t;

endpackage

// File: src/block_transfer_receiver_top.sv
// ----------------------------------------------------------------------------
// Block transfer receiver top level
// Session controller for the receiving end of a block transfer carried over
// control messages (SOH, EOT, CAN): replies, block delivery and session status.
// ----------------------------------------------------------------------------
// Usage:
// Input words (item, item_valid/item_ready) carry one event each: a session
// start, a received control message or a receive timeout. Every input word
// produces exactly one result word (result, result_valid/result_ready) that
// names the reply to send (none, NAK, ACK or CAN), whether the block of an
// SOH is handed on, and the session status and block count after the word.
// The retry limit is written over the cfg channel, which is always ready; it
// should only be written while no word is in flight.
// An accepted input word waits in the input register and moves to the result
// register once that is empty or being emptied. The block takes one word per
// clock while results are taken; the session state is updated in the same
// cycle that moves a word from the input register to the result register.
// Reset clears the session to idle, the expected sequence to one, the error
// and block counts to zero, and the retry limit to ten. When the receiver of
// results stalls, the result register holds, the input register fills, and
// item_ready drops until the result is taken.
module block_transfer_receiver_top
    import btr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic [7:0] cfg_data
);

`include "block_transfer_receiver_top_defines.svh"

    // Configuration register.
    logic [7:0] retry_limit_reg;

    // Input register.
    logic  stage_valid_reg;
    item_t stage_reg;

    // Result register.
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    // Session state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  err_reg, err_next;
    logic        cancel_reg, cancel_next;
    logic [15:0] count_reg, count_next;

    logic       advance;
    logic       ended;
    logic       seq_match;
    logic [7:0] err_inc;

    // A word moves into the result register when the result register is
    // empty or is being emptied in this same cycle.
    assign advance = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            retry_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            seq_reg    <= SEQ_RESET;
            err_reg    <= '0;
            cancel_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            err_reg    <= err_next;
            cancel_reg <= cancel_next;
            count_reg  <= count_next;
        end
    end

    // The error count saturates rather than wrapping.
    assign err_inc = (err_reg == ERR_MAX) ? err_reg : err_reg + 8'd1;
    assign seq_match = (stage_reg.seq_first == seq_reg) &&
                       (stage_reg.seq_second == ~seq_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        seq_next    = seq_reg;
        err_next    = err_reg;
        cancel_next = cancel_reg;
        count_next  = count_reg;
        ended       = 1'b0;
        result_next = '0;
        result_next.reply_code = REPLY_NONE;
        result_next.session_status = STATUS_IDLE;

        if (stage_reg.operation == OP_START)
        begin
            // A start restarts the session from any phase.
            phase_next  = PH_HANDSHAKE;
            seq_next    = SEQ_RESET;
            err_next    = '0;
            cancel_next = 1'b0;
            count_next  = '0;
            if (retry_limit_reg == 8'd0)
            begin
                result_next.reply_code = REPLY_CAN;
                result_next.session_status = STATUS_ABORT;
                ended = 1'b1;
            end
            else
            begin
                result_next.reply_code = REPLY_NAK;
            end
        end
        else if (phase_reg != PH_IDLE &&
                 (stage_reg.operation == OP_MESSAGE || stage_reg.operation == OP_TIMEOUT))
        begin
            if (stage_reg.operation == OP_MESSAGE && stage_reg.command_code == CODE_CAN)
            begin
                // Two CAN messages in a row cancel the session.
                if (cancel_reg)
                begin
                    result_next.session_status = STATUS_CANCEL;
                    ended = 1'b1;
                end
                else
                begin
                    cancel_next = 1'b1;
                    if (phase_reg == PH_HANDSHAKE)
                    begin
                        if (err_reg >= retry_limit_reg)
                        begin
                            result_next.reply_code = REPLY_CAN;
                            result_next.session_status = STATUS_ABORT;
                            ended = 1'b1;
                        end
                        else
                        begin
                            result_next.reply_code = REPLY_NAK;
                        end
                    end
                end
            end
            else if (stage_reg.operation == OP_MESSAGE &&
                     stage_reg.command_code == CODE_SOH)
            begin
                phase_next  = PH_DATA;
                err_next    = '0;
                cancel_next = 1'b0;
                if (seq_match)
                begin
                    if (!stage_reg.space_ok)
                    begin
                        result_next.reply_code = REPLY_CAN;
                        result_next.session_status = STATUS_ABORT;
                        ended = 1'b1;
                    end
                    else if (!stage_reg.data_ok || stage_reg.block_len > MAX_BLOCK_LEN)
                    begin
                        // The count was cleared by this SOH, so it becomes one.
                        err_next = 8'd1;
                        if (retry_limit_reg <= 8'd1)
                        begin
                            result_next.reply_code = REPLY_CAN;
                            result_next.session_status = STATUS_ABORT;
                            ended = 1'b1;
                        end
                        else
                        begin
                            result_next.reply_code = REPLY_NAK;
                        end
                    end
                    else if (!stage_reg.sink_ok)
                    begin
                        result_next.reply_code = REPLY_NAK;
                    end
                    else
                    begin
                        result_next.reply_code = REPLY_ACK;
                        result_next.deliver = 1'b1;
                        result_next.delivered_len = stage_reg.block_len;
                        count_next = count_reg + 16'd1;
                        seq_next = seq_reg + 8'd1;
                    end
                end
                else
                begin
                    result_next.reply_code = REPLY_NAK;
                end
            end
            else if (stage_reg.operation == OP_MESSAGE &&
                     stage_reg.command_code == CODE_EOT && phase_reg == PH_DATA)
            begin
                cancel_next = 1'b0;
                result_next.reply_code = REPLY_ACK;
                result_next.session_status = STATUS_DONE;
                ended = 1'b1;
            end
            else
            begin
                // Unknown code, early EOT or timeout counts as an error.
                cancel_next = 1'b0;
                err_next = err_inc;
                if (err_inc >= retry_limit_reg)
                begin
                    result_next.reply_code = REPLY_CAN;
                    result_next.session_status = STATUS_ABORT;
                    ended = 1'b1;
                end
                else if (phase_reg == PH_HANDSHAKE)
                begin
                    result_next.reply_code = REPLY_NAK;
                end
            end
        end

        if (ended)
        begin
            phase_next = PH_IDLE;
        end
        else if (phase_next != PH_IDLE)
        begin
            result_next.session_status = STATUS_RUN;
        end
        result_next.blocks_received = count_next;
    end

    // A delivered block is always acknowledged.
    `BTR_ASSERT_IMPL(a_deliver_ack, result_valid_reg && result_reg.deliver,
        result_reg.reply_code == REPLY_ACK, "delivered block without ACK")

    // A length is reported only for a delivered block.
    `BTR_ASSERT_IMPL(a_len_deliver, result_valid_reg && result_reg.delivered_len != 8'd0,
        result_reg.deliver, "delivered length without delivery")

    // A result that ends the session leaves the receiver idle.
    `BTR_ASSERT_NEXT(a_end_idle, advance && ended, phase_reg == PH_IDLE,
        "session end did not return to idle")

    // The input side stalls only behind a full, stalled result register.
    `BTR_ASSERT_IMPL(a_stall_cause, !item_ready,
        stage_valid_reg && result_valid_reg && !result_ready,
        "input stalled without a downstream stall")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Block transfer receiver testbench
// Drives session starts, control messages and receive timeouts into the
// receiver and checks every result word against its directed table row or
// the bench's cycle-free model of the session logic. The table covers the
// corner cases first. Random sessions then follow under several retry
// limits, with bursts of idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import btr_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Result stall long enough to back the pipeline up into item_ready. It
    // starts inside the long clean session, where the sender never idles.
    localparam int LONG_HOLD = 60;
    localparam int LONG_HOLD_AT = 300;
    // After this many input words both sides stop idling.
    localparam int CALM_AFTER = 800;
    // Fewest words per retry-limit phase; the long session counts toward them.
    localparam int PHASE_WORDS = 100;
    localparam int NUM_PHASES = 6;
    // Cycles to wait after the last expected result before the verdict.
    localparam int DRAIN_CYCLES = 10;

    // One row of the directed table. When typed is set, the expected result
    // is the one written in the row; otherwise the bench model supplies it.
    typedef struct packed {
        item_t   word;
        logic    typed;
        result_t reply;
    } row_t;

    typedef enum logic [2:0] {
        WK_START,
        WK_SOH,
        WK_SOH_SKEW,
        WK_EOT,
        WK_CAN,
        WK_TIMEOUT,
        WK_STRAY,
        WK_NOISE
    } word_kind_t;

    // The directed part runs at the reset retry limit of ten.
    localparam int NUM_ROWS = 25;
    localparam row_t DIRECTED [0:NUM_ROWS-1] = '{
        // Nothing happens while no session is open.
        '{'{OP_MESSAGE, CODE_SOH, 8'h01, 8'hfe, 8'd5, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_IDLE, 16'd0}},
        '{'{OP_TIMEOUT, 8'hff, 8'hff, 8'hff, 8'd128, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_IDLE, 16'd0}},
        // Start opens the handshake with a NAK.
        '{'{OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        // Handshake errors: timeout, early EOT, a single CAN, unknown code.
        '{'{OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        '{'{OP_MESSAGE, CODE_EOT, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        '{'{OP_MESSAGE, CODE_CAN, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        '{'{OP_MESSAGE, 8'hff, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        // First SOH enters the data phase; longest and empty blocks.
        '{'{OP_MESSAGE, CODE_SOH, 8'h01, 8'hfe, 8'd128, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_ACK, 1'b1, 8'd128, STATUS_RUN, 16'd1}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h02, 8'hfd, 8'd0, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_ACK, 1'b1, 8'd0, STATUS_RUN, 16'd2}},
        // Bad complement byte, failed data read, consumer refusal.
        '{'{OP_MESSAGE, CODE_SOH, 8'h03, 8'h00, 8'd9, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h03, 8'hfc, 8'd9, 1'b0, 1'b1, 1'b1}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h03, 8'hfc, 8'd9, 1'b1, 1'b0, 1'b1}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        // Data-phase errors stay silent below the limit.
        '{'{OP_TIMEOUT, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        '{'{OP_MESSAGE, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        // A lone CAN in the data phase is forgotten by the next SOH.
        '{'{OP_MESSAGE, CODE_CAN, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_RUN, 16'd2}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h03, 8'hfc, 8'd127, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{REPLY_ACK, 1'b1, 8'd127, STATUS_RUN, 16'd3}},
        // Two CANs in a row cancel the session.
        '{'{OP_MESSAGE, CODE_CAN, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_RUN, 16'd3}},
        '{'{OP_MESSAGE, CODE_CAN, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_CANCEL, 16'd3}},
        '{'{OP_MESSAGE, CODE_EOT, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NONE, 1'b0, 8'd0, STATUS_IDLE, 16'd3}},
        // No buffer space aborts at once.
        '{'{OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h01, 8'hfe, 8'd16, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{REPLY_CAN, 1'b0, 8'd0, STATUS_ABORT, 16'd0}},
        // A clean session: wrong sequence first, then a block, then EOT.
        '{'{OP_START, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_NAK, 1'b0, 8'd0, STATUS_RUN, 16'd0}},
        '{'{OP_MESSAGE, CODE_SOH, 8'h02, 8'hfd, 8'd64, 1'b1, 1'b1, 1'b1}, 1'b0,
          '0},
        '{'{OP_MESSAGE, CODE_SOH, 8'h01, 8'hfe, 8'h55, 1'b1, 1'b1, 1'b1}, 1'b0,
          '0},
        '{'{OP_MESSAGE, CODE_EOT, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{REPLY_ACK, 1'b0, 8'd0, STATUS_DONE, 16'd1}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    item_t      item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // Bench copy of the session state and the retry limit register.
    phase_t      ses_phase = PH_IDLE;
    logic [7:0]  want_seq = SEQ_RESET;
    logic [7:0]  fault_count = '0;
    logic        cancel_pending = 1'b0;
    logic [15:0] block_total = '0;
    logic [7:0]  retry_lim = RETRY_LIMIT_RESET;

    // Results owed by the receiver, oldest first.
    result_t pending_replies[$];

    int failures = 0;
    int words_sent = 0;
    // Percentage that sets how often either side goes quiet in this phase.
    int idle_pct = 25;
    bit long_hold_done = 1'b0;

    block_transfer_receiver_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Session model: applies one input word to the bench state and returns
    // the result word the receiver owes for it.
    function automatic result_t next_reply(input item_t w);
        result_t r;
        logic    ended;
        r = '0;
        ended = 1'b0;
        if (w.operation == OP_START)
        begin
            // A start always restarts from scratch, whatever the phase.
            ses_phase = PH_HANDSHAKE;
            want_seq = SEQ_RESET;
            fault_count = '0;
            cancel_pending = 1'b0;
            block_total = '0;
            if (fault_count >= retry_lim)
            begin
                r.reply_code = REPLY_CAN;
                r.session_status = STATUS_ABORT;
                ended = 1'b1;
            end
            else
            begin
                r.reply_code = REPLY_NAK;
            end
        end
        else if (ses_phase != PH_IDLE &&
                 (w.operation == OP_MESSAGE || w.operation == OP_TIMEOUT))
        begin
            if (w.operation == OP_MESSAGE && w.command_code == CODE_CAN)
            begin
                if (cancel_pending)
                begin
                    r.session_status = STATUS_CANCEL;
                    ended = 1'b1;
                end
                else
                begin
                    cancel_pending = 1'b1;
                    // Only the handshake answers a single CAN.
                    if (ses_phase == PH_HANDSHAKE)
                    begin
                        if (fault_count >= retry_lim)
                        begin
                            r.reply_code = REPLY_CAN;
                            r.session_status = STATUS_ABORT;
                            ended = 1'b1;
                        end
                        else
                        begin
                            r.reply_code = REPLY_NAK;
                        end
                    end
                end
            end
            else if (w.operation == OP_MESSAGE && w.command_code == CODE_SOH)
            begin
                ses_phase = PH_DATA;
                fault_count = '0;
                cancel_pending = 1'b0;
                if (w.seq_first == want_seq && w.seq_second == ~want_seq)
                begin
                    if (!w.space_ok)
                    begin
                        r.reply_code = REPLY_CAN;
                        r.session_status = STATUS_ABORT;
                        ended = 1'b1;
                    end
                    else if (!w.data_ok || w.block_len > MAX_BLOCK_LEN)
                    begin
                        if (fault_count != ERR_MAX)
                            fault_count = fault_count + 8'd1;
                        if (fault_count >= retry_lim)
                        begin
                            r.reply_code = REPLY_CAN;
                            r.session_status = STATUS_ABORT;
                            ended = 1'b1;
                        end
                        else
                        begin
                            r.reply_code = REPLY_NAK;
                        end
                    end
                    else if (!w.sink_ok)
                    begin
                        r.reply_code = REPLY_NAK;
                    end
                    else
                    begin
                        r.reply_code = REPLY_ACK;
                        r.deliver = 1'b1;
                        r.delivered_len = w.block_len;
                        block_total = block_total + 16'd1;
                        want_seq = want_seq + 8'd1;
                    end
                end
                else
                begin
                    // Sequence mismatches are answered but not counted.
                    r.reply_code = REPLY_NAK;
                end
            end
            else if (w.operation == OP_MESSAGE && w.command_code == CODE_EOT &&
                     ses_phase == PH_DATA)
            begin
                cancel_pending = 1'b0;
                r.reply_code = REPLY_ACK;
                r.session_status = STATUS_DONE;
                ended = 1'b1;
            end
            else
            begin
                // Timeouts, unknown codes and an EOT during the handshake.
                cancel_pending = 1'b0;
                if (fault_count != ERR_MAX)
                    fault_count = fault_count + 8'd1;
                if (fault_count >= retry_lim)
                begin
                    r.reply_code = REPLY_CAN;
                    r.session_status = STATUS_ABORT;
                    ended = 1'b1;
                end
                else if (ses_phase == PH_HANDSHAKE)
                begin
                    r.reply_code = REPLY_NAK;
                end
            end
        end
        if (ended)
            ses_phase = PH_IDLE;
        else if (ses_phase != PH_IDLE)
            r.session_status = STATUS_RUN;
        r.blocks_received = block_total;
        return r;
    endfunction

    // Builds one input word of the given kind. Fields the kind does not fix
    // are random. SOH words carry the sequence the model expects next, unless skewed.
    function automatic item_t build_word(input word_kind_t kind, input bit clean);
        item_t w;
        w.operation = OP_MESSAGE;
        w.command_code = 8'($urandom);
        w.seq_first = 8'($urandom);
        w.seq_second = 8'($urandom);
        w.block_len = 8'($urandom_range(0, MAX_BLOCK_LEN));
        w.data_ok = 1'($urandom);
        w.sink_ok = 1'($urandom);
        w.space_ok = 1'($urandom);
        case (kind)
            WK_START:   w.operation = OP_START;
            WK_TIMEOUT: w.operation = OP_TIMEOUT;
            WK_EOT:     w.command_code = CODE_EOT;
            WK_CAN:     w.command_code = CODE_CAN;
            WK_NOISE:   w.operation = 2'($urandom_range(OP_START, OP_TIMEOUT));
            WK_SOH, WK_SOH_SKEW:
            begin
                w.command_code = CODE_SOH;
                w.seq_first = want_seq;
                w.seq_second = ~want_seq;
                case ($urandom_range(7))
                    0:       w.block_len = MAX_BLOCK_LEN;
                    1:       w.block_len = '0;
                    default: ;
                endcase
                if (clean)
                begin
                    w.data_ok = 1'b1;
                    w.sink_ok = 1'b1;
                    w.space_ok = 1'b1;
                end
                else
                begin
                    w.data_ok = ($urandom_range(15) != 0);
                    w.sink_ok = ($urandom_range(15) != 0);
                    w.space_ok = ($urandom_range(47) != 0);
                end
                if (kind == WK_SOH_SKEW)
                begin
                    case ($urandom_range(2))
                        0: w.seq_first = want_seq + 8'($urandom_range(1, 255));
                        1: w.seq_second = w.seq_second ^ 8'($urandom_range(1, 255));
                        default:
                        begin
                            // The sender repeating the previous block.
                            w.seq_first = want_seq - 8'd1;
                            w.seq_second = ~w.seq_first;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    // Offers one word and waits for it to be taken. The owed result is
    // queued at the accepting edge. A random pause may follow, in which case
    // valid drops; otherwise it stays up for the next word.
    task automatic send_word(input item_t w, input bit use_typed = 1'b0,
                             input result_t typed_reply = '0);
        result_t predicted;
        item <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        predicted = next_reply(w);
        pending_replies.push_back(use_typed ? typed_reply : predicted);
        words_sent++;
        if (words_sent < CALM_AFTER && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Mostly well-formed sessions: start, some handshake trouble, a run of
    // blocks with the odd error mixed in, then EOT, a double CAN or nothing.
    task automatic run_session(input int blocks, input bit clean);
        word_kind_t k;
        int         pick;
        send_word(build_word(WK_START, clean));
        if (!clean && $urandom_range(3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(2))
                    0:       k = WK_TIMEOUT;
                    1:       k = WK_STRAY;
                    default: k = WK_CAN;
                endcase
                send_word(build_word(k, clean));
            end
        end
        for (int b = 0; b < blocks; b++)
        begin
            pick = $urandom_range(99);
            if (clean || pick < 80)
                k = WK_SOH;
            else if (pick < 86)
                k = WK_SOH_SKEW;
            else if (pick < 90)
                k = WK_TIMEOUT;
            else if (pick < 94)
                k = WK_CAN;
            else if (pick < 97)
                k = WK_STRAY;
            else
                k = WK_NOISE;
            send_word(build_word(k, clean));
        end
        pick = $urandom_range(99);
        if (clean || pick < 60)
        begin
            send_word(build_word(WK_EOT, clean));
        end
        else if (pick < 80)
        begin
            send_word(build_word(WK_CAN, clean));
            send_word(build_word(WK_CAN, clean));
        end
    endtask

    // Drops valid and waits for every owed result, so that the block is
    // idle before the retry limit changes.
    task automatic settle;
        item_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_retry_limit(input logic [7:0] limit);
        cfg_data <= limit;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        retry_lim = limit;
    endtask

    // Main stimulus: reset, the directed table, then one random phase per
    // retry limit: 1, 255, 2, a random one from 3 to 254, 5 and 10.
    initial
    begin : stimulus
        logic [7:0] phase_limits [NUM_PHASES];
        int         phase_idle [NUM_PHASES];
        int         phase_start;
        phase_limits = '{8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), 8'd5, 8'd10};
        phase_idle = '{30, 0, 50, 20, 10, 40};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].reply);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_retry_limit(phase_limits[p]);
            idle_pct = phase_idle[p];
            phase_start = words_sent;
            // At the largest limit one long clean session wraps the sequence.
            if (phase_limits[p] == 8'd255)
                run_session(270, 1'b1);
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3)) send_word(build_word(WK_NOISE, 1'b0));
                run_session($urandom_range(0, 12), 1'b0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side. It idles in random bursts, holds off once for a long
    // stretch so that the block fills and drops item_ready, and stays ready
    // throughout the last part of the run.
    initial
    begin : result_sink
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!long_hold_done && words_sent >= LONG_HOLD_AT)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (words_sent < CALM_AFTER && $urandom_range(399) < idle_pct)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Every accepted result word is compared with the oldest owed one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result word with nothing expected: %h", result);
                failures++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (result.reply_code !== want.reply_code)
                begin
                    $error("reply_code: expected %0d, got %0d",
                           want.reply_code, result.reply_code);
                    failures++;
                end
                if (result.deliver !== want.deliver)
                begin
                    $error("deliver: expected %0d, got %0d", want.deliver, result.deliver);
                    failures++;
                end
                if (result.delivered_len !== want.delivered_len)
                begin
                    $error("delivered_len: expected %0d, got %0d",
                           want.delivered_len, result.delivered_len);
                    failures++;
                end
                if (result.session_status !== want.session_status)
                begin
                    $error("session_status: expected %0d, got %0d",
                           want.session_status, result.session_status);
                    failures++;
                end
                if (result.blocks_received !== want.blocks_received)
                begin
                    $error("blocks_received: expected %0d, got %0d",
                           want.blocks_received, result.blocks_received);
                    failures++;
                end
            end
        end
    end

    // Hang detection: any handshake on any channel restarts the count.
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
